// File: hdl/dgcc_pkg.sv
// Shared constants, operation codes and handshake structs for the graph cycle checker.
package dgcc_pkg;

  // Capacities
  localparam int MAX_VERTS = 1024;
  localparam int MAX_EDGES = 4096;

  // Derived widths
  localparam int VW     = $clog2(MAX_VERTS);   // vertex index
  localparam int EW     = $clog2(MAX_EDGES);   // edge slot index
  localparam int PW     = EW + 1;              // edge pointer, 0 = null
  localparam int CW     = VW + 1;              // vertex count / stack depth
  localparam int VCNT_W = 11;                  // vertex_count register
  localparam int CMD_W  = 2;
  localparam int COL_W  = 2;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Vertex colors
  localparam logic [COL_W-1:0] COL_WHITE = 2'd0;
  localparam logic [COL_W-1:0] COL_GRAY  = 2'd1;
  localparam logic [COL_W-1:0] COL_BLACK = 2'd2;

  // Datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
  localparam logic [OP_W-1:0] OP_ADD_REQ     = 5'd1;
  localparam logic [OP_W-1:0] OP_ADD_REJ     = 5'd2;
  localparam logic [OP_W-1:0] OP_ADD_WR      = 5'd3;
  localparam logic [OP_W-1:0] OP_CLR_START   = 5'd4;
  localparam logic [OP_W-1:0] OP_SWEEP_HEAD  = 5'd5;
  localparam logic [OP_W-1:0] OP_CHK_START   = 5'd6;
  localparam logic [OP_W-1:0] OP_SWEEP_COLOR = 5'd7;
  localparam logic [OP_W-1:0] OP_ROOT_RD     = 5'd8;
  localparam logic [OP_W-1:0] OP_ROOT_NEXT   = 5'd9;
  localparam logic [OP_W-1:0] OP_ROOT_PUSH   = 5'd10;
  localparam logic [OP_W-1:0] OP_TOP_HEAD    = 5'd11;
  localparam logic [OP_W-1:0] OP_POP         = 5'd12;
  localparam logic [OP_W-1:0] OP_POP_RD      = 5'd13;
  localparam logic [OP_W-1:0] OP_EDGE_RD     = 5'd14;
  localparam logic [OP_W-1:0] OP_EDGE        = 5'd15;
  localparam logic [OP_W-1:0] OP_PUSH        = 5'd16;
  localparam logic [OP_W-1:0] OP_OUT_ACYC    = 5'd17;
  localparam logic [OP_W-1:0] OP_OUT_CYC     = 5'd18;

  // Controller to datapath
  typedef struct packed {
    logic [OP_W-1:0] op;
  } dgcc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             add_reject;
    logic             sweep_last;
    logic             root_end;
    logic [COL_W-1:0] color;
    logic             cur_null;
    logic             depth_one;
    logic             depth_full;
    logic             out_busy;
  } dgcc_status_t;

endpackage

// File: hdl/dgcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dgcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/dgcc_datapath.sv
// Datapath: edge store, list heads, colors, search stack and result register.
module dgcc_datapath
  import dgcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dgcc_cmd_t         cmd,
  output dgcc_status_t      status,
  input  logic              cfg_wr_en,
  input  logic [VCNT_W-1:0] cfg_wr_data,
  input  logic [VW-1:0]     src_vertex,
  input  logic [VW-1:0]     dst_vertex,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              acyclic,
  output logic              edges_dropped
);

  logic [VCNT_W-1:0] vertex_count;
  logic [CW-1:0]     n_act;
  logic [PW-1:0]     edges_used;
  logic              drop_flag;
  logic [VW-1:0]     cnt;
  logic [CW-1:0]     root;
  logic [CW-1:0]     depth;
  logic [VW-1:0]     top_v;
  logic [PW-1:0]     top_c;
  logic [VW-1:0]     d_r;
  logic [VW-1:0]     src_r;
  logic [VW-1:0]     dst_r;

  // RAM ports
  logic              head_we;
  logic [VW-1:0]     head_waddr, head_raddr;
  logic [PW-1:0]     head_wdata, head_rdata;
  logic              edge_we;
  logic [EW-1:0]     edge_raddr;
  logic [VW+PW-1:0]  edge_wdata, edge_rdata;
  logic              col_we;
  logic [VW-1:0]     col_waddr, col_raddr;
  logic [COL_W-1:0]  col_wdata, col_rdata;
  logic              stk_we;
  logic [VW-1:0]     stk_waddr, stk_raddr;
  logic [VW+PW-1:0]  stk_wdata, stk_rdata;

  logic [PW-1:0]     c_m1;
  logic [CW-1:0]     depth_m1, depth_m2;
  logic [VW-1:0]     edge_tgt;
  logic [PW-1:0]     edge_lnk;

  assign n_act    = (vertex_count > VCNT_W'(MAX_VERTS)) ? CW'(MAX_VERTS) : CW'(vertex_count);
  assign c_m1     = top_c - PW'(1);
  assign depth_m1 = depth - CW'(1);
  assign depth_m2 = depth - CW'(2);
  assign edge_tgt = edge_rdata[VW+PW-1:PW];
  assign edge_lnk = edge_rdata[PW-1:0];

  // Status back to the controller
  always_comb begin
    status.add_reject = ({1'b0, src_vertex} >= n_act) || ({1'b0, dst_vertex} >= n_act) ||
                        (edges_used >= PW'(MAX_EDGES));
    status.sweep_last = (cnt == VW'(MAX_VERTS - 1));
    status.root_end   = (root >= n_act);
    status.color      = col_rdata;
    status.cur_null   = (top_c == '0) || (top_c > PW'(MAX_EDGES));
    status.depth_one  = (depth == CW'(1));
    status.depth_full = (depth == CW'(MAX_VERTS));
    status.out_busy   = out_valid && out_stall;
  end

  // Memory address and write selection
  always_comb begin
    head_we    = 1'b0;
    head_waddr = src_r;
    head_wdata = edges_used + PW'(1);
    head_raddr = src_vertex;
    edge_we    = 1'b0;
    edge_wdata = {dst_r, head_rdata};
    edge_raddr = c_m1[EW-1:0];
    col_we     = 1'b0;
    col_waddr  = cnt;
    col_wdata  = COL_WHITE;
    col_raddr  = root[VW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = depth_m1[VW-1:0];
    stk_wdata  = {top_v, top_c};
    stk_raddr  = depth_m2[VW-1:0];
    case (cmd.op)
      OP_ADD_WR: begin
        head_we = 1'b1;
        edge_we = 1'b1;
      end
      OP_SWEEP_HEAD: begin
        head_we    = 1'b1;
        head_waddr = cnt;
        head_wdata = '0;
      end
      OP_SWEEP_COLOR: begin
        col_we = 1'b1;
      end
      OP_ROOT_PUSH: begin
        col_we     = 1'b1;
        col_waddr  = root[VW-1:0];
        col_wdata  = COL_GRAY;
        head_raddr = root[VW-1:0];
      end
      OP_POP: begin
        col_we    = 1'b1;
        col_waddr = top_v;
        col_wdata = COL_BLACK;
      end
      OP_EDGE: begin
        col_raddr = edge_tgt;
      end
      OP_PUSH: begin
        col_we     = 1'b1;
        col_waddr  = d_r;
        col_wdata  = COL_GRAY;
        stk_we     = 1'b1;
        head_raddr = d_r;
      end
      default: begin
      end
    endcase
  end

  dgcc_ram #(.WIDTH(PW), .DEPTH(MAX_VERTS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );

  dgcc_ram #(.WIDTH(VW + PW), .DEPTH(MAX_EDGES)) u_edge (
    .clk(clk), .we(edge_we), .waddr(edges_used[EW-1:0]), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  dgcc_ram #(.WIDTH(COL_W), .DEPTH(MAX_VERTS)) u_color (
    .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
    .raddr(col_raddr), .rdata(col_rdata)
  );

  dgcc_ram #(.WIDTH(VW + PW), .DEPTH(MAX_VERTS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCNT_W'(MAX_VERTS);
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edges_used <= '0;
      drop_flag  <= 1'b0;
      cnt        <= '0;
      root       <= '0;
      depth      <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A new result beat wins over retiring the old one
      if (cmd.op == OP_OUT_ACYC || cmd.op == OP_OUT_CYC) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_ADD_REJ:     drop_flag <= 1'b1;
        OP_ADD_WR:      edges_used <= edges_used + PW'(1);
        OP_CLR_START: begin
          cnt        <= '0;
          edges_used <= '0;
          drop_flag  <= 1'b0;
        end
        OP_SWEEP_HEAD:  cnt <= cnt + VW'(1);
        OP_SWEEP_COLOR: cnt <= cnt + VW'(1);
        OP_CHK_START: begin
          cnt  <= '0;
          root <= '0;
        end
        OP_ROOT_NEXT:   root <= root + CW'(1);
        OP_ROOT_PUSH:   depth <= CW'(1);
        OP_POP: begin
          depth <= depth_m1;
          if (depth == CW'(1)) begin
            root <= root + CW'(1);
          end
        end
        OP_PUSH:        depth <= depth + CW'(1);
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ADD_REQ: begin
        src_r <= src_vertex;
        dst_r <= dst_vertex;
      end
      OP_ROOT_PUSH: top_v <= root[VW-1:0];
      OP_TOP_HEAD:  top_c <= head_rdata;
      OP_POP_RD: begin
        top_v <= stk_rdata[VW+PW-1:PW];
        top_c <= stk_rdata[PW-1:0];
      end
      OP_EDGE: begin
        top_c <= edge_lnk;
        d_r   <= edge_tgt;
      end
      OP_PUSH:      top_v <= d_r;
      OP_OUT_ACYC: begin
        acyclic       <= 1'b1;
        edges_dropped <= drop_flag;
      end
      OP_OUT_CYC: begin
        acyclic       <= 1'b0;
        edges_dropped <= drop_flag;
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CW'(MAX_VERTS))
    else $error("stack depth beyond capacity");

  a_edges_bound: assert property (@(posedge clk) disable iff (rst)
    edges_used <= PW'(MAX_EDGES))
    else $error("edge count beyond capacity");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUSH) |-> (depth < CW'(MAX_VERTS)))
    else $error("push on full stack");

  a_root_depth: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_ROOT_PUSH) |=> (depth == CW'(1)))
    else $error("root push did not start a fresh stack");

endmodule

// File: hdl/dgcc_ctrl.sv
// Controller: sequences edge loads, clearing sweeps and the depth-first search.
module dgcc_ctrl
  import dgcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] command,
  input  dgcc_status_t     status,
  output dgcc_cmd_t        cmd
);

  localparam logic [3:0] ST_CLR       = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_ADD       = 4'd2;
  localparam logic [3:0] ST_CCLR      = 4'd3;
  localparam logic [3:0] ST_ROOT      = 4'd4;
  localparam logic [3:0] ST_RCOL      = 4'd5;
  localparam logic [3:0] ST_RHEAD     = 4'd6;
  localparam logic [3:0] ST_STEP      = 4'd7;
  localparam logic [3:0] ST_EDGE      = 4'd8;
  localparam logic [3:0] ST_ECOL      = 4'd9;
  localparam logic [3:0] ST_PHEAD     = 4'd10;
  localparam logic [3:0] ST_POPRD     = 4'd11;
  localparam logic [3:0] ST_DONE_ACYC = 4'd12;
  localparam logic [3:0] ST_DONE_CYC  = 4'd13;

  logic [3:0] state, state_next;

  assign in_stall = (state != ST_IDLE);

  // Next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      ST_CLR: begin
        cmd.op = OP_SWEEP_HEAD;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_ADD: begin
              if (status.add_reject) begin
                cmd.op = OP_ADD_REJ;
              end else begin
                cmd.op     = OP_ADD_REQ;
                state_next = ST_ADD;
              end
            end
            CMD_CHECK: begin
              cmd.op     = OP_CHK_START;
              state_next = ST_CCLR;
            end
            CMD_CLEAR: begin
              cmd.op     = OP_CLR_START;
              state_next = ST_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD: begin
        cmd.op     = OP_ADD_WR;
        state_next = ST_IDLE;
      end
      ST_CCLR: begin
        cmd.op = OP_SWEEP_COLOR;
        if (status.sweep_last) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (status.root_end) begin
          state_next = ST_DONE_ACYC;
        end else begin
          cmd.op     = OP_ROOT_RD;
          state_next = ST_RCOL;
        end
      end
      ST_RCOL: begin
        if (status.color != COL_WHITE) begin
          cmd.op     = OP_ROOT_NEXT;
          state_next = ST_ROOT;
        end else begin
          cmd.op     = OP_ROOT_PUSH;
          state_next = ST_RHEAD;
        end
      end
      ST_RHEAD, ST_PHEAD: begin
        cmd.op     = OP_TOP_HEAD;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (status.cur_null) begin
          cmd.op     = OP_POP;
          state_next = status.depth_one ? ST_ROOT : ST_POPRD;
        end else begin
          cmd.op     = OP_EDGE_RD;
          state_next = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cmd.op     = OP_EDGE;
        state_next = ST_ECOL;
      end
      ST_ECOL: begin
        if (status.color == COL_GRAY) begin
          state_next = ST_DONE_CYC;
        end else if (status.color == COL_WHITE && !status.depth_full) begin
          cmd.op     = OP_PUSH;
          state_next = ST_PHEAD;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_POPRD: begin
        cmd.op     = OP_POP_RD;
        state_next = ST_STEP;
      end
      ST_DONE_ACYC: begin
        if (!status.out_busy) begin
          cmd.op     = OP_OUT_ACYC;
          state_next = ST_IDLE;
        end
      end
      ST_DONE_CYC: begin
        if (!status.out_busy) begin
          cmd.op     = OP_OUT_CYC;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register; reset starts with the list-head clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/directed_graph_cycle_check.sv
// Directed graph cycle checker: per-vertex edge lists in RAM, DFS cycle search.
// Loads directed edges into per-vertex linked lists and, on a check beat, runs a
// three-color depth-first search with an explicit stack in RAM, returning one result
// beat (acyclic, edges_dropped). Add edge and clear beats return nothing. After reset
// and after each clear beat the block sweeps the list-head RAM with in_stall high.
// An add edge beat reads the list head, then makes the linked write; a rejected one
// only sets the dropped flag. A check sweeps the color RAM, then reads the color of
// each start vertex and pushes a fresh one, reads each edge followed and the color of
// its target, pushing a white target while the stack has room, and pops; these steps
// follow from the registered reads of the color, list-head, edge and stack RAMs.
// A new beat is accepted while a finished result still waits in the output register.
module directed_graph_cycle_check
  import dgcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [VCNT_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [VW-1:0]     src_vertex,
  input  logic [VW-1:0]     dst_vertex,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              acyclic,
  output logic              edges_dropped
);

  dgcc_cmd_t    cmd;
  dgcc_status_t status;

  dgcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .status   (status),
    .cmd      (cmd)
  );

  dgcc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .src_vertex    (src_vertex),
    .dst_vertex    (dst_vertex),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .acyclic       (acyclic),
    .edges_dropped (edges_dropped)
  );

endmodule
